// ===== rtl/hds_pkg.sv =====
// Shared widths, register indexes, reset values and pipeline tag type of the heat stencil.
package hds_pkg;

   localparam int TEMP_W      = 32;
   localparam int GAIN_W      = 16;
   localparam int ROWS_W      = 13;
   localparam int COLS_W      = 6;
   localparam int FRAC_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam int LAP_W  = TEMP_W + 2;
   localparam int PROD_W = LAP_W + GAIN_W + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam int QUO_W  = ACC_W - FRAC_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_X      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_Y      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE = 2'd3;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd8;
   localparam logic [COLS_W-1:0] COLS_RESET = 6'd8;

   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic vld;
      logic is_grid;
      logic emit;
      logic on_border;
      logic last;
   } tag_type;

endpackage

// ===== rtl/hds_req_if.sv =====
// Input channel carrying grid temperatures in raster order.
interface hds_req_if import hds_pkg::*; ();
   logic     valid;
   logic     ready;
   temp_type temperature;
   logic     final_point;

   modport source (output valid, output temperature, output final_point, input ready);
   modport sink (input valid, input temperature, input final_point, output ready);
endinterface

// ===== rtl/hds_rsp_if.sv =====
// Result channel carrying updated temperatures in raster order.
interface hds_rsp_if import hds_pkg::*; ();
   logic     valid;
   logic     ready;
   temp_type new_temperature;
   logic     last_result;

   modport source (output valid, output new_temperature, output last_result, input ready);
   modport sink (input valid, input new_temperature, input last_result, output ready);
endinterface

// ===== rtl/hds_line_buf.sv =====
// Two row buffers with registered reads and per-entry valid bits.
module hds_line_buf import hds_pkg::*; #(
   parameter int MAX_COLS = 32,
   localparam int CW = $clog2(MAX_COLS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic [CW-1:0] rd_addr,
   input  logic [CW-1:0] nb_addr,
   input  logic          cur_we,
   input  logic [CW-1:0] cur_wr_addr,
   input  temp_type      cur_wr_data,
   input  logic          above_we,
   input  logic [CW-1:0] above_wr_addr,
   input  temp_type      above_wr_data,
   output temp_type      ctr_q,
   output temp_type      right_q,
   output temp_type      up_q
);

   temp_type             cur_mem_ff [MAX_COLS];
   temp_type             above_mem_ff [MAX_COLS];
   logic [MAX_COLS-1:0]  cur_ok_ff;
   logic [MAX_COLS-1:0]  above_ok_ff;
   temp_type             ctr_raw_ff;
   temp_type             right_raw_ff;
   temp_type             up_raw_ff;
   logic                 ctr_ok_ff;
   logic                 right_ok_ff;
   logic                 up_ok_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ctr_raw_ff   <= cur_mem_ff[rd_addr];
         right_raw_ff <= cur_mem_ff[nb_addr];
         ctr_ok_ff    <= cur_ok_ff[rd_addr];
         right_ok_ff  <= cur_ok_ff[nb_addr];
         if (cur_we) begin
            cur_mem_ff[cur_wr_addr] <= cur_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         up_raw_ff <= above_mem_ff[rd_addr];
         up_ok_ff  <= above_ok_ff[rd_addr];
         if (above_we) begin
            above_mem_ff[above_wr_addr] <= above_wr_data;
         end
      end
   end

   // Entries never written read as zero, as after a full clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ok_ff   <= '0;
         above_ok_ff <= '0;
      end else if (en) begin
         if (cur_we) begin
            cur_ok_ff[cur_wr_addr] <= 1'b1;
         end
         if (above_we) begin
            above_ok_ff[above_wr_addr] <= 1'b1;
         end
      end
   end

   assign ctr_q   = ctr_ok_ff ? ctr_raw_ff : '0;
   assign right_q = right_ok_ff ? right_raw_ff : '0;
   assign up_q    = up_ok_ff ? up_raw_ff : '0;

endmodule

// ===== rtl/hds_update.sv =====
// Stencil arithmetic: weighted Laplacian products, then rounding and saturation; border points keep their centre value.
module hds_update import hds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  tag_type           in_tag,
   input  temp_type          ctr,
   input  temp_type          up,
   input  temp_type          down,
   input  temp_type          left,
   input  temp_type          right,
   input  logic [GAIN_W-1:0] gain_x,
   input  logic [GAIN_W-1:0] gain_y,
   output tag_type           out_tag,
   output temp_type          result
);

   logic signed [LAP_W-1:0] lap_x;
   logic signed [LAP_W-1:0] lap_y;
   prod_type                prod_x_in;
   prod_type                prod_y_in;
   prod_type                prod_x_ff;
   prod_type                prod_y_ff;
   temp_type                ctr_ff;
   tag_type                 tag_ff;
   logic signed [ACC_W-1:0] acc;
   logic signed [QUO_W-1:0] quo;
   logic                    fits;

   assign lap_x = LAP_W'(up) + LAP_W'(down) - (LAP_W'(ctr) <<< 1);
   assign lap_y = LAP_W'(left) + LAP_W'(right) - (LAP_W'(ctr) <<< 1);

   assign prod_x_in = $signed({1'b0, gain_x}) * lap_x;
   assign prod_y_in = $signed({1'b0, gain_y}) * lap_y;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         ctr_ff    <= ctr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= in_tag;
      end
   end

   // Half is added before the floor shift, so ties round upwards.
   assign acc = (ACC_W'(ctr_ff) <<< FRAC_W) + ACC_W'(prod_x_ff) + ACC_W'(prod_y_ff)
              + (ACC_W'(1) <<< (FRAC_W - 1));
   assign quo  = acc[ACC_W-1:FRAC_W];
   assign fits = (quo[QUO_W-1:TEMP_W-1] == '0) || (quo[QUO_W-1:TEMP_W-1] == '1);

   always_comb begin
      if (tag_ff.on_border) begin
         result = ctr_ff;
      end else if (fits) begin
         result = quo[TEMP_W-1:0];
      end else if (quo[QUO_W-1]) begin
         result = {1'b1, {(TEMP_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(TEMP_W-1){1'b1}}};
      end
   end

   assign out_tag = tag_ff;

endmodule

// ===== rtl/heat_diffusion_stencil_2d.sv =====
// Top level of the streaming five-point heat equation stencil with two row buffers.
// A result passes the input stage, registered row-buffer read, product and output registers.
// One grid point is taken every cycle unless the output stalls or a drain runs;
// the results trail the input by one grid row. A final point stalls the input while
// the buffered points drain, at most the column count. Reset is synchronous: it restores
// the register defaults, empties the pipeline and makes both row buffers read as zero.
module heat_diffusion_stencil_2d import hds_pkg::*; #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   hds_req_if.sink                req,
   hds_rsp_if.source              rsp,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int NW  = $clog2(MAX_COLS + 1);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int RCW = (RW > ROWS_W) ? RW : ROWS_W;

   logic [GAIN_W-1:0] gain_x_ff;
   logic [GAIN_W-1:0] gain_y_ff;
   logic [ROWS_W-1:0] rows_ff;
   logic [COLS_W-1:0] cols_ff;

   logic [NW-1:0]     ncol;
   logic [CW-1:0]     last_col;
   logic [CW-1:0]     col;
   logic              adv;
   logic              take;
   logic              emit;
   logic              on_border;

   logic [CW-1:0]     col_ff;
   logic [CW-1:0]     col_in;
   logic [RW-1:0]     row_ff;
   logic [RW-1:0]     row_in;
   logic              flush_ff;
   logic              flush_in;
   logic [CW-1:0]     fk_ff;
   logic [CW-1:0]     fk_in;
   logic [CW-1:0]     fend_ff;
   logic [CW-1:0]     fend_in;

   tag_type           tag1_ff;
   tag_type           tag1_in;
   logic [CW-1:0]     c1_ff;
   logic [CW-1:0]     c1_in;
   temp_type          v1_ff;
   temp_type          v1_in;
   logic [CW-1:0]     nb_addr;

   tag_type           tag2_ff;
   logic [CW-1:0]     c2_ff;
   temp_type          v2_ff;
   temp_type          ctr_q;
   temp_type          right_q;
   temp_type          up_q;
   temp_type          prev_ctr_ff;

   tag_type           tag3;
   temp_type          result;

   logic              out_vld_ff;
   temp_type          out_temp_ff;
   logic              out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff <= GAIN_RESET;
         gain_y_ff <= GAIN_RESET;
         rows_ff   <= ROWS_RESET;
         cols_ff   <= COLS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_X:      gain_x_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_Y:      gain_y_ff <= csr_wdata[GAIN_W-1:0];
            CSR_ROWS_IN_USE: rows_ff   <= csr_wdata[ROWS_W-1:0];
            CSR_COLS_IN_USE: cols_ff   <= csr_wdata[COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cols_ff == '0) begin
         ncol = NW'(1);
      end else if (cols_ff > COLS_W'(MAX_COLS)) begin
         ncol = NW'(MAX_COLS);
      end else begin
         ncol = cols_ff[NW-1:0];
      end
   end

   assign last_col  = CW'(ncol - NW'(1));
   assign col       = (col_ff > last_col) ? last_col : col_ff;
   assign emit      = (row_ff != '0);
   assign on_border = (row_ff == RW'(1)) || (RCW'(row_ff) >= RCW'(rows_ff))
                   || (col == '0) || (col == last_col);

   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv && !flush_ff;
   assign take      = req.valid && req.ready;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      flush_in = flush_ff;
      fk_in    = fk_ff;
      fend_in  = fend_ff;
      tag1_in  = '0;
      c1_in    = col;
      v1_in    = req.temperature;
      if (flush_ff) begin
         tag1_in.vld       = 1'b1;
         tag1_in.emit      = 1'b1;
         tag1_in.on_border = 1'b1;
         tag1_in.last      = (fk_ff == fend_ff);
         c1_in             = fk_ff;
         v1_in             = '0;
         fk_in             = (fk_ff == last_col) ? '0 : fk_ff + CW'(1);
         if (fk_ff == fend_ff) begin
            flush_in = 1'b0;
         end
      end else if (take) begin
         tag1_in.vld       = 1'b1;
         tag1_in.is_grid   = 1'b1;
         tag1_in.emit      = emit;
         tag1_in.on_border = on_border;
         if (req.final_point) begin
            col_in   = '0;
            row_in   = '0;
            flush_in = 1'b1;
            fend_in  = col;
            fk_in    = (emit && col != last_col) ? col + CW'(1) : '0;
         end else if (col == last_col) begin
            col_in = '0;
            if (row_ff < RW'(MAX_ROWS - 1)) begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         flush_ff <= 1'b0;
         fk_ff    <= '0;
         fend_ff  <= '0;
         tag1_ff  <= '0;
         tag2_ff  <= '0;
      end else if (adv) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         flush_ff <= flush_in;
         fk_ff    <= fk_in;
         fend_ff  <= fend_in;
         tag1_ff  <= tag1_in;
         tag2_ff  <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff <= c1_in;
         v1_ff <= v1_in;
         c2_ff <= c1_ff;
         v2_ff <= v1_ff;
         if (tag2_ff.vld && tag2_ff.is_grid) begin
            prev_ctr_ff <= ctr_q;
         end
      end
   end

   assign nb_addr = (c1_ff == CW'(MAX_COLS - 1)) ? '0 : c1_ff + CW'(1);

   hds_line_buf #(
      .MAX_COLS (MAX_COLS)
   ) u_line_buf (
      .clock         (clock),
      .reset         (reset),
      .en            (adv),
      .rd_addr       (c1_ff),
      .nb_addr       (nb_addr),
      .cur_we        (tag1_ff.vld && tag1_ff.is_grid),
      .cur_wr_addr   (c1_ff),
      .cur_wr_data   (v1_ff),
      .above_we      (tag2_ff.vld && tag2_ff.is_grid),
      .above_wr_addr (c2_ff),
      .above_wr_data (ctr_q),
      .ctr_q         (ctr_q),
      .right_q       (right_q),
      .up_q          (up_q)
   );

   // The left neighbour is the centre value of the previous grid point.
   hds_update u_update (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_tag  (tag2_ff),
      .ctr     (ctr_q),
      .up      (up_q),
      .down    (v2_ff),
      .left    (prev_ctr_ff),
      .right   (right_q),
      .gain_x  (gain_x_ff),
      .gain_y  (gain_y_ff),
      .out_tag (tag3),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= tag3.vld && tag3.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_temp_ff <= result;
         out_last_ff <= tag3.last;
      end
   end

   assign rsp.valid           = out_vld_ff;
   assign rsp.new_temperature = out_temp_ff;
   assign rsp.last_result     = out_last_ff;

   a_last_after_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_result) |-> !flush_ff)
      else $error("Last result of a grid transferred while the drain is still running.");

   a_drain_in_row: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> (fk_ff <= last_col) && (fend_ff <= last_col))
      else $error("Drain pointer outside the active row.");

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !(req.valid && req.ready))
      else $error("Input transfer taken while the pipeline is stalled.");

endmodule

// ===== tb/sv/tb_heat_diffusion_stencil_2d.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the streaming five-point heat equation stencil.
module tb_heat_diffusion_stencil_2d;
   import hds_pkg::*;

   localparam int MAX_COLS          = 32;
   localparam int MAX_ROWS          = 4096;
   localparam int SETTLE_CYCLES     = 12;
   localparam int HOLD_CYCLES       = 400;
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int RANDOM_POINTS     = 260;
   localparam int PRINT_LIMIT       = 100;
   localparam temp_type TEMP_MAX    = 32'h7FFF_FFFF;
   localparam temp_type TEMP_MIN    = 32'h8000_0000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {STYLE_SMOOTH, STYLE_RANDOM, STYLE_EXTREME} temp_style_type;

   typedef struct {
      temp_type value;
      logic     last;
   } grid_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   hds_req_if req_if ();
   hds_rsp_if rsp_if ();

   logic [GAIN_W-1:0] gain_x_cfg;
   logic [GAIN_W-1:0] gain_y_cfg;
   logic [ROWS_W-1:0] rows_cfg;
   logic [COLS_W-1:0] cols_cfg;

   temp_type        row_above [MAX_COLS];
   temp_type        row_current [MAX_COLS];
   int unsigned     row_pos;
   int unsigned     col_pos;
   grid_result_type pending_results [$];

   int       send_idle_pct   = 0;
   int       recv_stall_pct  = 0;
   int       hold_requests   = 0;
   int       hold_served     = 0;
   int       mismatch_count  = 0;
   int       points_taken    = 0;
   int       results_checked = 0;
   int       frames_sent     = 0;
   int       quiet_cycles    = 0;
   temp_type frame_base      = '0;

   always #5 clock = ~clock;

   heat_diffusion_stencil_2d DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic temp_type diffuse_point(temp_type up, temp_type down, temp_type left,
                                             temp_type right, temp_type ctr);
      longint centre;
      longint lap_x;
      longint lap_y;
      longint acc;
      longint q;
      centre = ctr;
      lap_x  = longint'(up) + longint'(down) - 2 * centre;
      lap_y  = longint'(left) + longint'(right) - 2 * centre;
      acc    = centre * 65536 + longint'(gain_x_cfg) * lap_x
               + longint'(gain_y_cfg) * lap_y + 32768;
      q      = acc >>> FRAC_W;
      if (q > longint'(TEMP_MAX)) begin
         q = longint'(TEMP_MAX);
      end
      if (q < longint'(TEMP_MIN)) begin
         q = longint'(TEMP_MIN);
      end
      return temp_type'(q);
   endfunction

   function automatic void advance_stencil(temp_type point, logic fin);
      int unsigned width;
      int unsigned c;
      int unsigned r;
      int unsigned k;
      temp_type    ctr;
      temp_type    up;
      temp_type    left;
      temp_type    right;
      temp_type    res;
      logic        border;
      width = 32'(cols_cfg);
      if (width < 1) begin
         width = 1;
      end
      if (width > MAX_COLS) begin
         width = MAX_COLS;
      end
      c = (col_pos > width - 1) ? width - 1 : col_pos;
      r = row_pos;
      if (r >= 1) begin
         ctr    = row_current[c];
         up     = row_above[c];
         left   = (c > 0) ? row_above[c - 1] : '0;
         right  = (c + 1 < width) ? row_current[c + 1] : '0;
         border = (r == 1) || (r >= rows_cfg) || (c == 0) || (c == width - 1);
         res    = border ? ctr : diffuse_point(up, point, left, right, ctr);
         pending_results.push_back('{res, 1'b0});
      end
      row_above[c]   = row_current[c];
      row_current[c] = point;
      if (fin) begin
         // The rest of the previous row leaves first, then the part of this row received.
         if (r >= 1) begin
            for (k = c + 1; k < width; k++) begin
               pending_results.push_back('{row_current[k], 1'b0});
            end
         end
         for (k = 0; k <= c; k++) begin
            pending_results.push_back('{row_current[k], k == c});
         end
         row_pos = 0;
         col_pos = 0;
      end else if (c >= width - 1) begin
         col_pos = 0;
         if (row_pos < MAX_ROWS - 1) begin
            row_pos++;
         end
      end else begin
         col_pos = c + 1;
      end
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t: result %0d: %s is %0h, expected %0h",
                  $time, results_checked, field, got, want);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      grid_result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_COLS; i++) begin
            row_above[i]   = '0;
            row_current[i] = '0;
         end
         row_pos = 0;
         col_pos = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            advance_stencil(req_if.temperature, req_if.final_point);
            points_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transfer, new_temperature",
                               rsp_if.new_temperature, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.new_temperature !== want.value) begin
                  report_mismatch("new_temperature", rsp_if.new_temperature, want.value);
               end
               if (rsp_if.last_result !== want.last) begin
                  report_mismatch("last_result", rsp_if.last_result, want.last);
               end
            end
            results_checked++;
         end
      end
   end

   initial begin : receiver
      int hold_left;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("tb_heat_diffusion_stencil_2d failed");
         $finish;
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 62;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 62;
         end
         default: begin
            send_idle_pct  = 19;
            recv_stall_pct = 19;
         end
      endcase
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      case (index)
         CSR_GAIN_X:      gain_x_cfg = value[GAIN_W-1:0];
         CSR_GAIN_Y:      gain_y_cfg = value[GAIN_W-1:0];
         CSR_ROWS_IN_USE: rows_cfg   = value[ROWS_W-1:0];
         default:         cols_cfg   = value[COLS_W-1:0];
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_point(input temp_type value, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.temperature <= value;
      req_if.final_point <= fin;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
   endtask

   // Lets the block drain and settle so that registers may be written safely.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic temp_type pick_temperature(input temp_style_type style);
      case (style)
         STYLE_SMOOTH:
            return frame_base + temp_type'($urandom_range(0, 'h7FFFF)) - temp_type'('h40000);
         STYLE_RANDOM:
            return temp_type'($urandom);
         default: begin
            case ($urandom_range(0, 9))
               0:       return TEMP_MAX;
               1:       return TEMP_MIN;
               2:       return '0;
               3:       return -1;
               4:       return 1;
               default: return temp_type'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic int unsigned pick_gain();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         return 0;
      end else if (pick < 20) begin
         return 65535;
      end
      return $urandom_range(0, 65535);
   endfunction

   task automatic send_frame(input int count, input logic with_final,
                             input temp_style_type style);
      frame_base = temp_type'($urandom) >>> 2;
      for (int i = 0; i < count; i++) begin
         send_point(pick_temperature(style), with_final && (i == count - 1));
      end
      frames_sent++;
   endtask

   task automatic test_small_grid();
      temp_type grid [9] = '{0, TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN,
                             TEMP_MAX, TEMP_MIN, TEMP_MAX, 1};
      wait_idle();
      write_reg(CSR_ROWS_IN_USE, 3);
      write_reg(CSR_COLS_IN_USE, 3);
      for (int i = 0; i < 9; i++) begin
         send_point(grid[i], i == 8);
      end
      frames_sent++;
   endtask

   task automatic test_gain_extremes();
      temp_type grid [9] = '{TEMP_MIN, TEMP_MAX, TEMP_MIN, TEMP_MAX, 0,
                             TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN};
      wait_idle();
      write_reg(CSR_GAIN_X, 65535);
      write_reg(CSR_GAIN_Y, 65535);
      for (int i = 0; i < 9; i++) begin
         send_point(grid[i], i == 8);
      end
      frames_sent++;
   endtask

   task automatic test_early_final();
      wait_idle();
      write_reg(CSR_GAIN_X, 0);
      write_reg(CSR_GAIN_Y, 0);
      write_reg(CSR_ROWS_IN_USE, 4);
      write_reg(CSR_COLS_IN_USE, 4);
      send_frame(6, 1'b1, STYLE_RANDOM);
   endtask

   task automatic test_first_row_final();
      wait_idle();
      send_frame(2, 1'b1, STYLE_EXTREME);
   endtask

   task automatic test_random_frames();
      int                sent;
      int                pick;
      int                width;
      int                rows_n;
      int                total;
      int                count;
      logic              with_final;
      logic [ROWS_W-1:0] rows_value;
      logic [COLS_W-1:0] cols_value;
      sent = 0;
      for (int frame = 0; sent < RANDOM_POINTS; frame++) begin
         wait_idle();
         set_idling(idle_mode_type'(frame % 4));
         pick = $urandom_range(99);
         if (pick < 6) begin
            cols_value = COLS_W'($urandom_range(0, 2));
         end else if (pick < 12) begin
            cols_value = COLS_W'($urandom_range(33, 63));
         end else if (pick < 20) begin
            cols_value = COLS_W'(MAX_COLS);
         end else begin
            cols_value = COLS_W'($urandom_range(3, 10));
         end
         pick = $urandom_range(99);
         if (pick < 6) begin
            rows_value = ROWS_W'($urandom_range(0, 2));
         end else if (pick < 10) begin
            rows_value = ROWS_W'(MAX_ROWS);
         end else if (pick < 13) begin
            rows_value = ROWS_W'($urandom_range(MAX_ROWS + 1, 8191));
         end else begin
            rows_value = ROWS_W'($urandom_range(3, 6));
         end
         write_reg(CSR_GAIN_X, pick_gain());
         write_reg(CSR_GAIN_Y, pick_gain());
         write_reg(CSR_ROWS_IN_USE, 32'(rows_value));
         write_reg(CSR_COLS_IN_USE, 32'(cols_value));
         width = (cols_value < 1) ? 1 : (cols_value > MAX_COLS) ? MAX_COLS : int'(cols_value);
         rows_n = (rows_value >= 3 && rows_value <= 6) ? int'(rows_value)
                                                       : int'($urandom_range(2, 5));
         total = width * rows_n;
         // Most frames are whole; some end early and some stay open across a new setting.
         pick = $urandom_range(99);
         count = (pick < 75) ? total : int'($urandom_range(1, total));
         with_final = (pick < 88);
         send_frame(count, with_final, temp_style_type'($urandom_range(0, 2)));
         sent += count;
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      set_idling(IDLE_NONE);
      write_reg(CSR_GAIN_X, pick_gain());
      write_reg(CSR_GAIN_Y, pick_gain());
      write_reg(CSR_ROWS_IN_USE, 5);
      write_reg(CSR_COLS_IN_USE, MAX_COLS);
      hold_requests++;
      send_frame(3 * MAX_COLS, 1'b0, STYLE_SMOOTH);
      wait_idle();
      send_frame(2 * MAX_COLS, 1'b1, STYLE_SMOOTH);
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_GAIN_X;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.temperature = '0;
      req_if.final_point = 1'b0;
      gain_x_cfg         = GAIN_RESET;
      gain_y_cfg         = GAIN_RESET;
      rows_cfg           = ROWS_RESET;
      cols_cfg           = COLS_RESET;
      set_idling(IDLE_NONE);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_small_grid();
      test_gain_extremes();
      test_early_final();
      test_first_row_final();
      test_random_frames();
      test_backpressure();
      wait_idle();

      $display("Run covered %0d grid points in %0d frames; %0d results checked, %0d mismatches.",
               points_taken, frames_sent, results_checked, mismatch_count);
      $display("It included gain and size extremes, early and missing final points ",
               "and a long output hold-off that filled the pipeline.");
      if (mismatch_count == 0) begin
         $display("tb_heat_diffusion_stencil_2d passed");
      end else begin
         $display("tb_heat_diffusion_stencil_2d failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hds_pkg.sv
rtl/hds_req_if.sv
rtl/hds_rsp_if.sv
rtl/hds_line_buf.sv
rtl/hds_update.sv
rtl/heat_diffusion_stencil_2d.sv
tb/sv/tb_heat_diffusion_stencil_2d.sv
